// ===== src/etdq_pkg.sv =====
// Package for the deadline timer queue: codes, cell control and state types.
// No dependencies; used by the cell and the top level.
package etdq_pkg;

  localparam logic [16:0] PRESCALE_MAX = 17'h10000;
  localparam logic [15:0] REV_STEP     = 16'd2;
  localparam int          NUM_SLOTS    = 8;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_NEW    = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXPIRED = 3'd1,
    ST_STALE   = 3'd2,
    ST_LATE    = 3'd3,
    ST_BUSY    = 3'd4,
    ST_READ    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_PRESCALE = 2'd0,
    CFG_RUN_HOLD = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_EXEC   = 2'd1,
    FSM_EXPIRE = 2'd2
  } fsm_t;

  typedef enum logic [1:0] {
    CM_HOLD       = 2'd0,
    CM_LOAD_NEW   = 2'd1,
    CM_FROM_LEFT  = 2'd2,
    CM_FROM_RIGHT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t  mode;
    logic [63:0] q_dl;
    logic [2:0]  q_slot;
    logic [63:0] now;
  } cell_ctl_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] dl;
    logic [2:0]  slot;
  } cell_st_t;

  typedef struct packed {
    logic le_new;
    logic match;
    logic expd;
  } cell_flag_t;

endpackage

// ===== src/etdq_if.sv =====
// Channel interfaces for the deadline timer queue: request and result.
// Depends on nothing; plain valid/ready with payload.
interface etdq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  req_id;
  logic [63:0] deadline_in;
  logic [31:0] delay_in;
  logic [15:0] req_rev;
  modport source (output valid, req_type, req_id, deadline_in, delay_in, req_rev,
                  input ready);
  modport sink   (input valid, req_type, req_id, deadline_in, delay_in, req_rev,
                  output ready);
endinterface

interface etdq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  entry_id;
  logic [63:0] time_value;
  logic [15:0] config_revision;
  logic        last_result;
  modport source (output valid, status, entry_id, time_value, config_revision,
                  last_result, input ready);
  modport sink   (input valid, status, entry_id, time_value, config_revision,
                  last_result, output ready);
endinterface

// ===== src/extended_timer_deadline_queue_top.sv =====
// Top level of the deadline timer: counter, control sequencer, cell chain.
// Depends on etdq_pkg, etdq_if and etdq_cell.
//
//  channel | dir | transaction
//  in_ch   | in  | tick / new / cancel / read request
//  out_ch  | out | one result (status, id, time, revision, last)
//  cfg_*   | in  | register write, no handshake
//
// A request is accepted, then executed against the cell chain; a tick is
// accepted, then counts, then checks the head, removing one expired entry
// per check and shifting the chain each time, until the head is unexpired.
// Reset is synchronous; no clearing pass. A stalled result holds the sequencer
// in any step that delivers a result; requests are taken only in the idle step.
module extended_timer_deadline_queue_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  etdq_in_if.sink     in_ch,
  etdq_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [16:0] cfg_wdata
);
  import etdq_pkg::*;

  fsm_t        state_r, state_nxt;
  logic [1:0]  rq_type_r;
  logic [2:0]  rq_id_r;
  logic [63:0] rq_dl_r;
  logic [31:0] rq_delay_r;
  logic [15:0] rq_rev_r;
  logic [63:0] time_r, time_nxt;
  logic [16:0] phase_r, phase_nxt, prescale_r;
  logic        run_hold_r;
  logic [15:0] rev_r;
  logic [NUM_SLOTS-1:0] pending_r, pending_nxt;

  logic        out_valid_r, out_load;
  logic [2:0]  out_status_r, out_status_nxt, out_id_r, out_id_nxt;
  logic [63:0] out_tv_r, out_tv_nxt;
  logic        out_last_r, out_last_nxt;

  cell_ctl_t  ctl   [QUEUE_DEPTH];
  cell_st_t   cst   [QUEUE_DEPTH];
  cell_flag_t flg   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le_new, match, expd, vld, seen, new_at;

  logic [63:0] new_dl;
  logic        out_free, stale, do_insert, do_cancel, do_head;
  logic [16:0] ps_w;

  assign out_free = !out_valid_r || out_ch.ready;
  assign new_dl   = (rq_delay_r != 32'd0) ? time_r + {32'd0, rq_delay_r} : rq_dl_r;
  assign stale    = (rq_rev_r != 16'd0) && (rq_rev_r != rev_r);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le_new[i] = flg[i].le_new;
      match[i]  = flg[i].match;
      expd[i]   = flg[i].expd;
      vld[i]    = cst[i].valid;
    end
    seen[0]   = match[0];
    new_at[0] = !le_new[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      seen[i]   = seen[i-1] | match[i];
      new_at[i] = !le_new[i] && le_new[i-1];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (in_ch.valid) state_nxt = FSM_EXEC;
      FSM_EXEC: begin
        if (req_type_t'(rq_type_r) == REQ_TICK) state_nxt = FSM_EXPIRE;
        else if (out_free) state_nxt = FSM_IDLE;
      end
      FSM_EXPIRE: if (!expd[0]) state_nxt = FSM_IDLE;
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_id_nxt     = rq_id_r;
    out_tv_nxt     = time_r;
    out_last_nxt   = 1'b1;
    do_insert      = 1'b0;
    do_cancel      = 1'b0;
    do_head        = 1'b0;
    pending_nxt    = pending_r;
    time_nxt       = time_r;
    phase_nxt      = phase_r;
    case (state_r)
      FSM_EXEC: begin
        case (req_type_t'(rq_type_r))
          REQ_TICK: begin
            if (vld[0] || run_hold_r) begin
              if (17'(phase_r + 17'd1) >= prescale_r) begin
                phase_nxt = '0;
                time_nxt  = time_r + 64'd1;
              end else begin
                phase_nxt = 17'(phase_r + 17'd1);
              end
            end
          end
          REQ_NEW: begin
            out_load = out_free;
            if (stale) begin
              out_status_nxt = ST_STALE;
            end else if (pending_r[rq_id_r]) begin
              out_status_nxt = ST_BUSY;
            end else if (new_dl <= time_r) begin
              out_status_nxt = ST_LATE;
              out_tv_nxt     = new_dl;
            end else if (vld[QUEUE_DEPTH-1]) begin
              out_status_nxt = ST_BUSY;
            end else begin
              out_status_nxt = ST_OK;
              out_tv_nxt     = new_dl;
              do_insert      = out_free;
              if (out_free) pending_nxt[rq_id_r] = 1'b1;
            end
          end
          REQ_CANCEL: begin
            out_load = out_free;
            if (pending_r[rq_id_r]) begin
              out_status_nxt = ST_OK;
              do_cancel      = out_free;
              if (out_free) pending_nxt[rq_id_r] = 1'b0;
            end else begin
              out_status_nxt = ST_LATE;
            end
          end
          default: begin
            out_load       = out_free;
            out_status_nxt = ST_READ;
            out_id_nxt     = '0;
          end
        endcase
      end
      FSM_EXPIRE: begin
        if (expd[0] && out_free) begin
          out_load       = 1'b1;
          do_head        = 1'b1;
          out_status_nxt = ST_EXPIRED;
          out_id_nxt     = cst[0].slot;
          out_tv_nxt     = cst[0].dl;
          out_last_nxt   = !expd[1];
          pending_nxt[cst[0].slot] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ctl[i].q_dl   = (state_r == FSM_EXEC) ? new_dl : rq_dl_r;
      ctl[i].q_slot = rq_id_r;
      ctl[i].now    = time_r;
      if (do_insert)      ctl[i].mode = new_at[i] ? CM_LOAD_NEW :
                                        (!le_new[i] ? CM_FROM_LEFT : CM_HOLD);
      else if (do_cancel) ctl[i].mode = seen[i] ? CM_FROM_RIGHT : CM_HOLD;
      else if (do_head)   ctl[i].mode = CM_FROM_RIGHT;
      else                ctl[i].mode = CM_HOLD;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    cell_st_t lft, rgt;
    if (g == 0) begin : g_l0
      assign lft = '0;
    end else begin : g_l
      assign lft = cst[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_rn
      assign rgt = '0;
    end else begin : g_r
      assign rgt = cst[g+1];
    end
    etdq_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl[g]), .left(lft), .right(rgt),
      .st(cst[g]), .flg(flg[g])
    );
  end

  always_comb begin
    ps_w = cfg_wdata;
    if (cfg_wdata == 17'd0) ps_w = 17'd1;
    else if (cfg_wdata > PRESCALE_MAX) ps_w = PRESCALE_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      time_r      <= '0;
      phase_r     <= '0;
      prescale_r  <= 17'd1;
      run_hold_r  <= 1'b0;
      rev_r       <= 16'd1;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      time_r    <= time_nxt;
      pending_r <= pending_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_we && cfg_idx_t'(cfg_idx) == CFG_PRESCALE) begin
        prescale_r <= ps_w;
        phase_r    <= '0;
        rev_r      <= rev_r + REV_STEP;
      end else begin
        phase_r    <= phase_nxt;
      end
      if (cfg_we && cfg_idx_t'(cfg_idx) == CFG_RUN_HOLD) run_hold_r <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      rq_type_r  <= in_ch.req_type;
      rq_id_r    <= in_ch.req_id;
      rq_dl_r    <= in_ch.deadline_in;
      rq_delay_r <= in_ch.delay_in;
      rq_rev_r   <= in_ch.req_rev;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_tv_r     <= out_tv_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign in_ch.ready            = (state_r == FSM_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.entry_id        = out_id_r;
  assign out_ch.time_value      = out_tv_r;
  assign out_ch.config_revision = rev_r;
  assign out_ch.last_result     = out_last_r;

  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    !vld[0] |-> (vld == '0))
    else $error("queue cells not contiguous");
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pending_r) == $countones(vld))
    else $error("pending slots and queue entries disagree");
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_EXPIRE && out_load && !out_last_nxt) |=> expd[0])
    else $error("expiry marked not last but head not expired");

endmodule

// ===== src/etdq_cell.sv =====
// One queue cell: holds a deadline and slot, shifts to/from its neighbors.
// Depends on etdq_pkg.
module etdq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  etdq_pkg::cell_ctl_t ctl,
  input  etdq_pkg::cell_st_t  left,
  input  etdq_pkg::cell_st_t  right,
  output etdq_pkg::cell_st_t  st,
  output etdq_pkg::cell_flag_t flg
);
  import etdq_pkg::*;

  cell_st_t st_r, st_nxt;

  always_comb begin
    case (ctl.mode)
      CM_LOAD_NEW:   st_nxt = '{valid: 1'b1, dl: ctl.q_dl, slot: ctl.q_slot};
      CM_FROM_LEFT:  st_nxt = left;
      CM_FROM_RIGHT: st_nxt = right;
      default:       st_nxt = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= st_nxt.valid;
    end
    st_r.dl   <= st_nxt.dl;
    st_r.slot <= st_nxt.slot;
  end

  assign st         = st_r;
  assign flg.le_new = st_r.valid && (st_r.dl <= ctl.q_dl);
  assign flg.match  = st_r.valid && (st_r.slot == ctl.q_slot);
  assign flg.expd   = st_r.valid && (st_r.dl <= ctl.now);

endmodule
